// ===== sv/round_robin_quantum_scheduler_defines.svh =====
`ifndef ROUND_ROBIN_QUANTUM_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_QUANTUM_SCHEDULER_DEFINES_SVH

// checked property, quiet while reset is held
`define RRQS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked property that also holds across reset
`define RRQS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/rrqs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rrqs_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int ID_W      = 8;
  localparam int TIME_W    = 16;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_SERVE  = 1'b1;

  typedef enum logic [1:0] {
    ST_SERVED   = 2'd0,
    ST_DONE     = 2'd1,
    ST_INSERTED = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // one process table entry
  typedef struct packed {
    logic [TIME_W-1:0] quota;
    logic [TIME_W-1:0] remaining;
    logic [ID_W-1:0]   id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller to datapath
  typedef struct packed {
    logic insert;       // insert item accepted
    logic start;        // serve item accepted, a runnable entry exists
    logic idle_result;  // serve item accepted, nothing runnable
    logic finish;       // entry read back, update and load the result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic has_work;
  } stat_t;

endpackage

`default_nettype wire

// ===== sv/round_robin_quantum_scheduler.sv =====
// Round-robin process scheduler with a per-process time quantum. The block holds a
// table of up to rrqs_pkg::MAX_PROCS processes (id, remaining time, quota) in one
// registered-read RAM, plus a runnable bit per entry in flip-flops. An insert item
// (tuser = 0) appends a process and answers inserted, or table full when the table is
// already at capacity. A serve item (tuser = 1) runs a rotating priority search over
// the runnable bits from the current position in the cycle it is accepted and reads
// the chosen entry; the next cycle subtracts the quota (clamped at zero), writes the
// entry back and loads the result. A serve with no runnable process answers all done.
// Every item gives exactly one result, held in an output register; a new item is taken
// while no serve is in progress and that register is empty or being drained in the
// same cycle. Entries are only ever read below the fill count, so the table needs no
// clearing after reset.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_quantum_scheduler (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [39:0] s_tdata,   // process_id[7:0], time_needed[23:8], turn_quota[39:24]
  input  wire logic        s_tuser,   // mode
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [23:0] m_tdata,   // served_id[7:0], time_left[23:8]
  output      logic [1:0]  m_tuser    // status
);

  rrqs_pkg::cmd_t                cmd;
  rrqs_pkg::stat_t               stat;
  rrqs_pkg::status_t             out_status;
  logic [rrqs_pkg::ID_W-1:0]     out_id;
  logic [rrqs_pkg::TIME_W-1:0]   out_left;

  // sequencing: accept, two-step serve, result register handshake
  rrqs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_mode   (s_tuser),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // process table, search, quota subtract and result payload
  rrqs_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_id      (s_tdata[7:0]),
    .in_time    (s_tdata[23:8]),
    .in_quota   (s_tdata[39:24]),
    .out_status (out_status),
    .out_id     (out_id),
    .out_left   (out_left)
  );

  assign m_tdata = {out_left, out_id};
  assign m_tuser = out_status;

endmodule

`default_nettype wire

// ===== sv/rrqs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rrqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/rrqs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rrqs_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic           in_mode,
  output      logic           in_ready,
  output      logic           out_valid,
  input  wire logic           out_ready,
  input  wire rrqs_pkg::stat_t stat,
  output      rrqs_pkg::cmd_t  cmd
);

  typedef enum logic {
    S_IDLE,
    S_SERVE
  } state_t;

  state_t state;
  logic   out_free;
  logic   accept;
  logic   load;

  // result register can take a new value this cycle
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd             = '0;
    cmd.insert      = accept && (in_mode == rrqs_pkg::MODE_INSERT);
    cmd.start       = accept && (in_mode == rrqs_pkg::MODE_SERVE) && stat.has_work;
    cmd.idle_result = accept && (in_mode == rrqs_pkg::MODE_SERVE) && !stat.has_work;
    cmd.finish      = (state == S_SERVE) && out_free;
  end

  assign load = cmd.insert || cmd.idle_result || cmd.finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.start) begin
            state <= S_SERVE;
          end
        end
        S_SERVE: begin
          if (cmd.finish) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/rrqs_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rrqs_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire rrqs_pkg::cmd_t                cmd,
  output      rrqs_pkg::stat_t               stat,
  input  wire logic [rrqs_pkg::ID_W-1:0]     in_id,
  input  wire logic [rrqs_pkg::TIME_W-1:0]   in_time,
  input  wire logic [rrqs_pkg::TIME_W-1:0]   in_quota,
  output      rrqs_pkg::status_t             out_status,
  output      logic [rrqs_pkg::ID_W-1:0]     out_id,
  output      logic [rrqs_pkg::TIME_W-1:0]   out_left
);

  logic [rrqs_pkg::CNT_W-1:0]     count;
  logic [rrqs_pkg::IDX_W-1:0]     pos;
  logic [rrqs_pkg::MAX_PROCS-1:0] flags;     // entry still has time left
  logic [rrqs_pkg::MAX_PROCS-1:0] active;
  logic [rrqs_pkg::IDX_W-1:0]     sel_idx;
  logic [rrqs_pkg::IDX_W-1:0]     hit_idx;
  logic [rrqs_pkg::IDX_W-1:0]     lo_idx;
  logic [rrqs_pkg::IDX_W-1:0]     hi_idx;
  logic                           lo_hit;
  logic                           hi_hit;
  logic                           full;
  logic                           do_insert;
  logic                           sel_last;
  logic [rrqs_pkg::TIME_W-1:0]    nrem;
  rrqs_pkg::entry_t               rd_entry;
  rrqs_pkg::entry_t               wr_entry;
  logic [rrqs_pkg::ENTRY_W-1:0]   rd_bits;
  logic [rrqs_pkg::IDX_W-1:0]     waddr;
  logic                           we;

  assign full      = (count == rrqs_pkg::CNT_W'(rrqs_pkg::MAX_PROCS));
  assign do_insert = cmd.insert && !full;

  // rotating priority search: first runnable entry at or after pos, else wrap
  always_comb begin
    lo_idx = '0;
    hi_idx = '0;
    lo_hit = 1'b0;
    hi_hit = 1'b0;
    for (int i = 0; i < rrqs_pkg::MAX_PROCS; i++) begin
      active[i] = flags[i] && (rrqs_pkg::CNT_W'(i) < count);
    end
    for (int i = rrqs_pkg::MAX_PROCS - 1; i >= 0; i--) begin
      if (active[i]) begin
        lo_idx = rrqs_pkg::IDX_W'(i);
        lo_hit = 1'b1;
        if (rrqs_pkg::IDX_W'(i) >= pos) begin
          hi_idx = rrqs_pkg::IDX_W'(i);
          hi_hit = 1'b1;
        end
      end
    end
  end

  assign hit_idx       = hi_hit ? hi_idx : lo_idx;
  assign stat.has_work = lo_hit;

  assign rd_entry = rrqs_pkg::entry_t'(rd_bits);
  assign nrem     = (rd_entry.quota >= rd_entry.remaining) ? '0
                  : rd_entry.remaining - rd_entry.quota;
  assign sel_last = (rrqs_pkg::CNT_W'(sel_idx) + rrqs_pkg::CNT_W'(1)) == count;

  always_comb begin
    if (cmd.finish) begin
      waddr              = sel_idx;
      wr_entry.id        = rd_entry.id;
      wr_entry.remaining = nrem;
      wr_entry.quota     = rd_entry.quota;
    end else begin
      waddr              = count[rrqs_pkg::IDX_W-1:0];
      wr_entry.id        = in_id;
      wr_entry.remaining = in_time;
      wr_entry.quota     = in_quota;
    end
  end

  assign we = do_insert || cmd.finish;

  rrqs_ram #(
    .WIDTH (rrqs_pkg::ENTRY_W),
    .DEPTH (rrqs_pkg::MAX_PROCS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_entry),
    .re    (cmd.start),
    .raddr (hit_idx),
    .rdata (rd_bits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pos   <= '0;
      flags <= '0;
    end else begin
      if (do_insert) begin
        flags[count[rrqs_pkg::IDX_W-1:0]] <= (in_time != '0);
        count                              <= count + rrqs_pkg::CNT_W'(1);
      end
      if (cmd.finish) begin
        flags[sel_idx] <= (nrem != '0);
        pos            <= sel_last ? '0 : sel_idx + rrqs_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sel_idx <= hit_idx;
    end
    if (cmd.insert) begin
      out_status <= full ? rrqs_pkg::ST_FULL : rrqs_pkg::ST_INSERTED;
      out_id     <= '0;
      out_left   <= '0;
    end else if (cmd.idle_result) begin
      out_status <= rrqs_pkg::ST_DONE;
      out_id     <= '0;
      out_left   <= '0;
    end else if (cmd.finish) begin
      out_status <= rrqs_pkg::ST_SERVED;
      out_id     <= rd_entry.id;
      out_left   <= nrem;
    end
  end

endmodule

`default_nettype wire

// ===== sv/rrqs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "round_robin_quantum_scheduler_defines.svh"

module rrqs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata,
  input wire logic [1:0]  m_tuser
);

  // a stalled result keeps its value
  `RRQS_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

  // nothing to deliver right after reset
  `RRQS_ASSERT_RST(a_rst, rst |=> !m_tvalid, "result valid after reset")

  // only a served result carries id and time
  `RRQS_ASSERT(a_zero, m_tvalid && (m_tuser != rrqs_pkg::ST_SERVED) |-> (m_tdata == 24'd0), "non-served result with payload")

  // an insert answers in the next cycle with inserted or full
  `RRQS_ASSERT(a_ins, s_tvalid && s_tready && (s_tuser == rrqs_pkg::MODE_INSERT) |=> m_tvalid && m_tuser[1], "insert result missing")

  // a serve item blocks input while its entry is read back, unless it answers all done at once
  `RRQS_ASSERT(a_srv, s_tvalid && s_tready && (s_tuser == rrqs_pkg::MODE_SERVE) |=> !s_tready || (m_tvalid && (m_tuser == rrqs_pkg::ST_DONE)), "input taken during serve")

endmodule

bind round_robin_quantum_scheduler rrqs_checker u_rrqs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
